// ===== rtl/core/two_stacks_shared_memory_core_assert.svh =====
// Assertion macros for the checker file of the two-stack core.
// Depends on nothing; included by bare file name.
`ifndef TWO_STACKS_SHARED_MEMORY_CORE_ASSERT_SVH
`define TWO_STACKS_SHARED_MEMORY_CORE_ASSERT_SVH

// Property checked on each rising edge, off while reset is asserted.
`define TSSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on each rising edge, reset cycles included.
`define TSSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tssm_pkg.sv =====
// Shared types and codes of the two-stack core: operations, status,
// result record, memory control and controller states. No dependencies.
package tssm_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_PUSH_LO = 3'd0,
        OP_PUSH_HI = 3'd1,
        OP_POP_LO  = 3'd2,
        OP_POP_HI  = 3'd3,
        OP_DISPLAY = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  data;
        logic                      stack_id;
        logic                      last;
    } t_res;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_WREAD,
        ST_WEMIT
    } t_state;

endpackage

// ===== rtl/core/tssm_ram.sv =====
// Word store shared by both stacks: one port, synchronous read with a
// registered output that holds while no read is issued. Uses tssm_pkg.
module tssm_ram #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  tssm_pkg::t_mem_ctl                i_ctl,
    input  logic [$clog2(DEPTH)-1:0]          i_addr,
    input  logic [tssm_pkg::WORD_W-1:0]       i_wdata,
    output logic [tssm_pkg::WORD_W-1:0]       o_rdata
);
    import tssm_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tssm_oreg.sv =====
// Output register of the two-stack core: holds one result request until
// the consumer takes it. Uses tssm_pkg for the result record.
module tssm_oreg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  tssm_pkg::t_res  i_res,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output tssm_pkg::t_res  o_res,
    output logic            o_free
);
    import tssm_pkg::*;

    logic r_valid;
    logic n_valid;
    t_res r_res;

    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        priority if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/core/tssm_ctrl.sv =====
// Controller of the two-stack core: stack pointers, request decode,
// memory read/write sequencing and the display walk. Uses tssm_pkg.
module tssm_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_operation,
    input  logic signed [31:0]            i_value,
    output tssm_pkg::t_mem_ctl            o_mem,
    output logic [$clog2(DEPTH)-1:0]      o_mem_addr,
    output logic [tssm_pkg::WORD_W-1:0]   o_mem_wdata,
    input  logic [tssm_pkg::WORD_W-1:0]   i_mem_rdata,
    input  logic                          i_out_free,
    output logic                          o_res_load,
    output tssm_pkg::t_res                o_res
);
    import tssm_pkg::*;

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] TOP      = PW'(DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    t_state        r_state, n_state;
    logic [PW-1:0] r_low, n_low;
    logic [PW-1:0] r_high, n_high;
    logic [PW-1:0] r_idx, n_idx;
    logic          r_phase, n_phase;
    t_status       r_stat, n_stat;
    logic          r_sid, n_sid;
    logic          r_last, n_last;
    logic          r_use_rd, n_use_rd;

    logic          accept;
    logic          both_empty;
    logic          walk_last;
    logic [PW-1:0] idx_inc;
    logic [PW-1:0] high_dec;
    logic [PW-1:0] low_dec;
    t_state        acc_state;

    function automatic logic [PW-1:0] idx_low_inc(input logic [PW-1:0] v);
        return v + PW'(1);
    endfunction

    assign both_empty = (r_low == '0) && (r_high == TOP);
    assign idx_inc    = r_idx + PW'(1);
    assign high_dec   = r_high - PW'(1);
    assign low_dec    = r_low - PW'(1);
    assign walk_last  = r_phase ? (r_idx == r_high)
                                : ((idx_inc == r_low) && (r_high == TOP));
    assign o_in_ready = (r_state == ST_IDLE) || ((r_state == ST_EMIT) && i_out_free);
    assign accept     = i_in_valid && o_in_ready;

    // State entered when a request is taken.
    always_comb begin
        unique case (i_operation)
            OP_PUSH_LO, OP_PUSH_HI, OP_POP_LO, OP_POP_HI: acc_state = ST_EMIT;
            OP_DISPLAY: acc_state = both_empty ? ST_EMIT : ST_WREAD;
            default:    acc_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                n_state = accept ? acc_state : ST_IDLE;
            end
            ST_EMIT: begin
                priority if (accept) begin
                    n_state = acc_state;
                end else if (i_out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_WREAD: begin
                n_state = ST_WEMIT;
            end
            ST_WEMIT: begin
                priority if (!i_out_free) begin
                    n_state = ST_WEMIT;
                end else if (r_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WREAD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_mem       = '0;
        o_mem_addr  = '0;
        o_mem_wdata = i_value;
        o_res_load  = 1'b0;
        n_low       = r_low;
        n_high      = r_high;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_stat      = r_stat;
        n_sid       = r_sid;
        n_last      = r_last;
        n_use_rd    = r_use_rd;

        unique case (r_state)
            ST_EMIT: begin
                o_res_load = i_out_free;
            end
            ST_WREAD: begin
                o_mem.rd_en = 1'b1;
                o_mem_addr  = r_idx[AW-1:0];
                n_stat      = STAT_OK;
                n_sid       = r_phase;
                n_last      = walk_last;
                n_use_rd    = 1'b1;
            end
            ST_WEMIT: begin
                o_res_load = i_out_free;
                // advance the walk; stack one ends, then stack two from the top entry
                if (i_out_free && !r_last) begin
                    priority if (r_phase) begin
                        n_idx = r_idx - PW'(1);
                    end else if (idx_inc == r_low) begin
                        n_phase = 1'b1;
                        n_idx   = LAST_IDX;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            n_last   = 1'b1;
            n_use_rd = 1'b0;
            unique case (i_operation)
                OP_PUSH_LO: begin
                    n_sid = 1'b0;
                    if (r_low == r_high) begin
                        n_stat = STAT_FULL;
                    end else begin
                        n_stat      = STAT_OK;
                        o_mem.wr_en = 1'b1;
                        o_mem_addr  = r_low[AW-1:0];
                        n_low       = idx_low_inc(r_low);
                    end
                end
                OP_PUSH_HI: begin
                    n_sid = 1'b1;
                    if (r_low == r_high) begin
                        n_stat = STAT_FULL;
                    end else begin
                        n_stat      = STAT_OK;
                        o_mem.wr_en = 1'b1;
                        o_mem_addr  = high_dec[AW-1:0];
                        n_high      = high_dec;
                    end
                end
                OP_POP_LO: begin
                    n_sid = 1'b0;
                    if (r_low == '0) begin
                        n_stat = STAT_EMPTY;
                    end else begin
                        n_stat      = STAT_OK;
                        n_use_rd    = 1'b1;
                        o_mem.rd_en = 1'b1;
                        o_mem_addr  = low_dec[AW-1:0];
                        n_low       = low_dec;
                    end
                end
                OP_POP_HI: begin
                    n_sid = 1'b1;
                    if (r_high == TOP) begin
                        n_stat = STAT_EMPTY;
                    end else begin
                        n_stat      = STAT_OK;
                        n_use_rd    = 1'b1;
                        o_mem.rd_en = 1'b1;
                        o_mem_addr  = r_high[AW-1:0];
                        n_high      = r_high + PW'(1);
                    end
                end
                OP_DISPLAY: begin
                    n_sid  = 1'b0;
                    n_stat = STAT_EMPTY;
                    // start on stack one unless it is empty
                    n_phase = (r_low == '0);
                    n_idx   = (r_low == '0) ? LAST_IDX : '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_low   <= '0;
            r_high  <= TOP;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_phase  <= n_phase;
        r_stat   <= n_stat;
        r_sid    <= n_sid;
        r_last   <= n_last;
        r_use_rd <= n_use_rd;
    end

    assign o_res.status   = r_stat;
    assign o_res.data     = r_use_rd ? signed'(i_mem_rdata) : '0;
    assign o_res.stack_id = r_sid;
    assign o_res.last     = r_last;

endmodule

// ===== rtl/core/two_stacks_shared_memory_core.sv =====
// Two stacks in one word store of DEPTH entries: stack one grows up from
// entry 0, stack two grows down from entry DEPTH-1. Push and pop requests
// give one result each; with the output taken every cycle a new push or
// pop request is accepted every cycle. Each result is registered in the
// controller, then loaded into the output register. Display gives one
// result per stored word (or one empty result) through the single memory
// port: each word is read, then moved to the output register. No request is
// taken during a display walk. The store needs no clearing after reset;
// only entries inside a stack are ever read. Uses tssm_pkg.
module two_stacks_shared_memory_core #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_operation,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_data,
    output logic                o_stack_id,
    output logic                o_last
);
    import tssm_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    logic              out_free;
    logic              res_load;
    t_res              res_next;
    t_res              res_out;

    tssm_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_mem       (mem_ctl),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res_next)
    );

    tssm_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    tssm_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_load),
        .i_res       (res_next),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_res       (res_out),
        .o_free      (out_free)
    );

    assign o_status   = res_out.status;
    assign o_data     = res_out.data;
    assign o_stack_id = res_out.stack_id;
    assign o_last     = res_out.last;

endmodule

// ===== rtl/core/tssm_checker.sv =====
// Port-level checks of the two-stack core, bound to the top level.
// Uses tssm_pkg and the assertion macros of the core's header.
`include "two_stacks_shared_memory_core_assert.svh"

module tssm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [1:0]          o_status,
    input logic signed [31:0]  o_data,
    input logic                o_stack_id,
    input logic                o_last
);
    import tssm_pkg::*;

    logic [35:0] out_word;

    assign out_word = {o_status, o_data, o_stack_id, o_last};

    `TSSM_ASSERT_ALWAYS(a_reset_drops_valid, i_clk, !i_rst_n |=> !o_out_valid, "valid after reset")

    `TSSM_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(out_word), "stalled result changed")

    `TSSM_ASSERT(a_fail_zero_last, i_clk, i_rst_n, o_out_valid && (o_status != STAT_OK) |-> o_data == 32'sd0 && o_last, "refused result not zero or not last")

    `TSSM_ASSERT(a_walk_ok, i_clk, i_rst_n, o_out_valid && !o_last |-> o_status == STAT_OK, "non-final result not ok")

    `TSSM_ASSERT(a_walk_blocks_in, i_clk, i_rst_n, o_out_valid && !o_last |-> !o_in_ready, "request taken during display")

endmodule

bind two_stacks_shared_memory_core tssm_checker u_checker (.*);
